@@ hw/rtl/mrep_pkg.sv @@
// Shared types, constants and codes for the mouse report assembler.
// No dependencies; imported by every module of the block.
`default_nettype none

package mrep_pkg;

    localparam int REPORT_BYTES = 32;
    localparam int REL_CODES    = 16;

    // internal byte index: axis writes top out at 1 + 4 + 14 = 19, the wheel byte at 1 + 4 + 15 = 20
    localparam int IDX_W = 6;
    localparam int ST_AW = $clog2(REPORT_BYTES);
    localparam int CNT_W = $clog2(REL_CODES);

    localparam logic [3:0]  SLOT_UNMAPPED = 4'hF;
    localparam logic [15:0] KIND_SYNC     = 16'd0;
    localparam logic [15:0] KIND_KEY      = 16'd1;
    localparam logic [15:0] KIND_REL      = 16'd2;
    localparam logic [15:0] KEY_GEAR_DOWN = 16'h0150;
    localparam logic [15:0] KEY_GEAR_UP   = 16'h0151;
    localparam logic [11:0] KEY_BTN_GROUP = 12'h011;

    typedef enum logic [2:0] {
        CFG_REPORT_ID   = 3'd0,
        CFG_NUM_BUTTONS = 3'd1,
        CFG_AXIS_BYTES  = 3'd2,
        CFG_WHEEL_FLAGS = 3'd3,
        CFG_SLOT_MAP    = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ALU_PASS = 3'd0,
        ALU_SAT  = 3'd1,
        ALU_INC  = 3'd2,
        ALU_DEC  = 3'd3,
        ALU_SET  = 3'd4,
        ALU_CLR  = 3'd5
    } alu_op_t;

    typedef struct packed {
        logic [15:0]        kind;
        logic [15:0]        event_code;
        logic signed [31:0] event_value;
    } event_t;

    typedef struct packed {
        logic       write_valid;
        logic [4:0] byte_index;
        logic [7:0] byte_value;
        logic       marks_dirty;
        logic       last;
    } result_t;

    typedef struct packed {
        alu_op_t            op;
        logic [IDX_W-1:0]   base;
        logic [IDX_W-1:0]   offset;
        logic [7:0]         operand;
        logic signed [31:0] value;
        logic [2:0]         bit_sel;
    } alu_req_t;

    typedef struct packed {
        logic             en;
        logic [ST_AW-1:0] addr;
        logic [7:0]       data;
    } st_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/mrep_store.sv @@
// Report byte store: one write port, one combinational read port.
// Depends on mrep_pkg; all bytes clear to zero at reset.
`default_nettype none

module mrep_store
    import mrep_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire st_wr_t           wr,
    input  wire logic [ST_AW-1:0] rd_addr,
    output logic [7:0]            rd_data
);

    logic [7:0] bytes_reg [REPORT_BYTES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REPORT_BYTES; i++)
            begin
                bytes_reg[i] <= 8'd0;
            end
        end
        else if (wr.en)
        begin
            bytes_reg[wr.addr] <= wr.data;
        end
    end

    assign rd_data = bytes_reg[rd_addr];

endmodule

`default_nettype wire

@@ hw/rtl/mrep_alu.sv @@
// Shared byte unit: index adder plus saturate, step and bit update of one byte.
// Depends on mrep_pkg; purely combinational, driven by the sequencer.
`default_nettype none

module mrep_alu
    import mrep_pkg::*;
(
    input  wire alu_req_t         req,
    output logic [IDX_W-1:0]      idx,
    output logic [7:0]            val
);

    logic [7:0] mask;

    assign idx  = req.base + req.offset;
    assign mask = 8'b1 << req.bit_sel;

    always_comb
    begin
        case (req.op)
            ALU_SAT:
            begin
                if (req.value < -32'sd127)
                    val = 8'h81;
                else if (req.value > 32'sd127)
                    val = 8'h7F;
                else
                    val = req.value[7:0];
            end
            ALU_INC: val = req.operand + 8'd1;
            ALU_DEC: val = req.operand - 8'd1;
            ALU_SET: val = req.operand | mask;
            ALU_CLR: val = req.operand & ~mask;
            default: val = req.operand;
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/input_event_to_mouse_report_unit.sv @@
// Mouse report assembler: sequencer, configuration registers and output register.
// Every event writes the report id first; a relative or key event that writes a byte
// then has its write step; a sync event walks the REL_CODES map slots, one per cycle
// while the output is not stalled, then the wheel byte; each event ends in a final step.
// One event at a time: in_stall stays high until the last result is loaded, the next
// request is taken once idle; output stalls hold it. Reset clears store and state.
`default_nettype none

module input_event_to_mouse_report_unit
    import mrep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire event_t      in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output result_t          out_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ID    = 7'b0000010,
        ST_REL   = 7'b0000100,
        ST_KEY   = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_WHEEL = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]  report_id_reg;
    logic [4:0]  num_buttons_reg;
    logic [3:0]  axis_bytes_reg;
    logic [4:0]  wheel_flags_reg;
    logic [63:0] slot_map_reg;

    event_t           ev_reg;
    logic             dirty_reg, dirty_next;
    logic [IDX_W-1:0] tgt_reg, tgt_next;
    alu_op_t          keyop_reg, keyop_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ST_AW-1:0] pend_idx_reg;
    logic [7:0]       pend_val_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic [IDX_W-1:0] axis_off, vwheel;
    logic [3:0]       rel_slot, scan_slot;
    logic             out_free, accept, gen, want, push, push_last, in_range;
    alu_req_t         alu_req;
    logic [IDX_W-1:0] alu_idx;
    logic [7:0]       alu_val;
    st_wr_t           st_wr;
    logic [7:0]       st_rd;

    assign axis_off = IDX_W'(6'd1 + 6'(({1'b0, num_buttons_reg} + 6'd7) >> 3));
    assign vwheel   = axis_off + IDX_W'(axis_bytes_reg);

    assign rel_slot  = (ev_reg.event_code < 16'(REL_CODES))
                     ? slot_map_reg[4 * ev_reg.event_code[CNT_W-1:0] +: 4] : SLOT_UNMAPPED;
    assign scan_slot = slot_map_reg[4 * cnt_reg +: 4];

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // operand selection for the shared unit
    always_comb
    begin
        alu_req         = '0;
        alu_req.op      = ALU_PASS;
        alu_req.value   = ev_reg.event_value;
        alu_req.bit_sel = ev_reg.event_code[2:0];
        want            = 1'b0;
        unique case (state_reg)
            ST_ID:
            begin
                alu_req.operand = report_id_reg;
                want            = 1'b1;
            end
            ST_REL:
            begin
                alu_req.op     = ALU_SAT;
                alu_req.base   = axis_off;
                alu_req.offset = IDX_W'(rel_slot);
                want           = 1'b1;
            end
            ST_KEY:
            begin
                alu_req.op      = keyop_reg;
                alu_req.base    = tgt_reg;
                alu_req.operand = st_rd;
                want            = 1'b1;
            end
            ST_SCAN:
            begin
                alu_req.base   = axis_off;
                alu_req.offset = IDX_W'(scan_slot);
                want           = (scan_slot != SLOT_UNMAPPED);
            end
            ST_WHEEL:
            begin
                alu_req.base = vwheel;
                want         = wheel_flags_reg[0] && !wheel_flags_reg[2];
            end
            default: ;
        endcase
    end

    mrep_alu u_alu (
        .req (alu_req),
        .idx (alu_idx),
        .val (alu_val)
    );

    // drop writes that fall outside the store
    assign in_range  = (alu_idx < IDX_W'(REPORT_BYTES));
    assign gen       = want && in_range && out_free;
    assign push      = gen && (state_reg != ST_ID);
    assign push_last = (state_reg == ST_FIN) && out_free;

    assign st_wr.en   = gen;
    assign st_wr.addr = alu_idx[ST_AW-1:0];
    assign st_wr.data = alu_val;

    mrep_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (st_wr),
        .rd_addr (tgt_reg[ST_AW-1:0]),
        .rd_data (st_rd)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        dirty_next = dirty_reg;
        tgt_next   = tgt_reg;
        keyop_next = keyop_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_ID;
                    dirty_next = 1'b0;
                end
            end
            ST_ID:
            begin
                if (out_free)
                begin
                    state_next = ST_FIN;
                    cnt_next   = '0;
                    if (ev_reg.kind == KIND_REL)
                    begin
                        if (rel_slot != SLOT_UNMAPPED)
                        begin
                            state_next = ST_REL;
                            dirty_next = 1'b1;
                        end
                    end
                    else if (ev_reg.kind == KIND_KEY)
                    begin
                        if (ev_reg.event_code == KEY_GEAR_DOWN
                            || ev_reg.event_code == KEY_GEAR_UP)
                        begin
                            if (ev_reg.event_value != 32'sd0 && wheel_flags_reg[0])
                            begin
                                state_next = ST_KEY;
                                dirty_next = 1'b1;
                                tgt_next   = vwheel;
                                keyop_next = (ev_reg.event_code == KEY_GEAR_DOWN)
                                           ? ALU_DEC : ALU_INC;
                            end
                        end
                        else if (ev_reg.event_code[15:4] == KEY_BTN_GROUP
                                 && {1'b0, ev_reg.event_code[3:0]} < num_buttons_reg)
                        begin
                            state_next = ST_KEY;
                            dirty_next = 1'b1;
                            tgt_next   = IDX_W'(6'd1 + {5'd0, ev_reg.event_code[3]});
                            keyop_next = (ev_reg.event_value != 32'sd0) ? ALU_SET : ALU_CLR;
                        end
                    end
                    else if (ev_reg.kind == KIND_SYNC)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_REL, ST_KEY, ST_WHEEL:
            begin
                if (out_free)
                    state_next = ST_FIN;
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(REL_CODES - 1))
                        state_next = ST_WHEEL;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dirty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;
            if (push || push_last)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload: event latch, pending write and output register
    always_ff @(posedge clk)
    begin
        tgt_reg   <= tgt_next;
        keyop_reg <= keyop_next;
        cnt_reg   <= cnt_next;
        if (accept)
            ev_reg <= in_data;
        if (gen)
        begin
            pend_idx_reg <= alu_idx[ST_AW-1:0];
            pend_val_reg <= alu_val;
        end
        // hold back one write so the final one can carry last
        if (push || push_last)
        begin
            out_reg.write_valid <= 1'b1;
            out_reg.byte_index  <= pend_idx_reg;
            out_reg.byte_value  <= pend_val_reg;
            out_reg.marks_dirty <= dirty_reg;
            out_reg.last        <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_id_reg   <= 8'd1;
            num_buttons_reg <= 5'd0;
            axis_bytes_reg  <= 4'd0;
            wheel_flags_reg <= 5'd0;
            slot_map_reg    <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_REPORT_ID:   report_id_reg   <= cfg_data[7:0];
                CFG_NUM_BUTTONS: num_buttons_reg <= cfg_data[4:0];
                CFG_AXIS_BYTES:  axis_bytes_reg  <= cfg_data[3:0];
                CFG_WHEEL_FLAGS: wheel_flags_reg <= cfg_data[4:0];
                CFG_SLOT_MAP:    slot_map_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_ID))
        else $error("accepted request did not start with the report id write");

    a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_WHEEL) |-> !dirty_reg)
        else $error("sync request marked dirty");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE || state_reg == ST_FIN) |-> !st_wr.en)
        else $error("store written outside a generating step");

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        push_last |=> (out_valid && out_data.last))
        else $error("final result not flagged last");

    a_last_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> !out_data.last)
        else $error("intermediate result flagged last");

endmodule

`default_nettype wire

@@ test/mouse_report_checker.sv @@
// Checker for the mouse report assembler: watches the config port and both request
// channels, keeps its own copy of the report bytes and predicts every byte write.
// Depends on mrep_pkg for the request types, codes and register indexes.

module mouse_report_checker
    import mrep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  event_t      in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  result_t     out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          mismatches,
    output int          backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  report_bytes [REPORT_BYTES];
    logic [7:0]  cur_report_id;
    logic [4:0]  cur_buttons;
    logic [3:0]  cur_axis_bytes;
    logic [4:0]  cur_wheel_flags;
    logic [63:0] cur_slot_map;

    result_t expected_writes[$];
    result_t batch[$];
    result_t want;

    function automatic logic [3:0] slot_for_code(logic [15:0] code);
        if (code >= REL_CODES)
            return SLOT_UNMAPPED;
        return cur_slot_map[4 * code[3:0] +: 4];
    endfunction

    function automatic logic [7:0] clamp_motion(logic signed [31:0] v);
        if (v < -127)
            return 8'h81;
        if (v > 127)
            return 8'h7F;
        return v[7:0];
    endfunction

    // writes past the end of the report are dropped and not reported
    task automatic record_write(int unsigned pos, logic [7:0] val);
        result_t r;
        if (pos < REPORT_BYTES)
        begin
            report_bytes[pos] = val;
            r.write_valid = 1'b1;
            r.byte_index  = pos[4:0];
            r.byte_value  = val;
            r.marks_dirty = 1'b0;
            r.last        = 1'b0;
            batch.push_back(r);
        end
    endtask

    task automatic predict_writes(event_t ev);
        int unsigned axis_base;
        int unsigned wheel_pos;
        int unsigned btn;
        int unsigned pos;
        logic [3:0]  slot;
        logic [7:0]  cur;
        logic [7:0]  mask;
        bit          changed;
        changed   = 1'b0;
        axis_base = 1 + (int'(cur_buttons) + 7) / 8;
        wheel_pos = axis_base + cur_axis_bytes;
        batch.delete();
        record_write(0, cur_report_id);
        case (ev.kind)
            KIND_REL:
            begin
                slot = slot_for_code(ev.event_code);
                if (slot != SLOT_UNMAPPED)
                begin
                    record_write(axis_base + slot, clamp_motion(ev.event_value));
                    changed = 1'b1;
                end
            end
            KIND_KEY:
            begin
                if (ev.event_code == KEY_GEAR_DOWN || ev.event_code == KEY_GEAR_UP)
                begin
                    if (ev.event_value != 0 && cur_wheel_flags[0])
                    begin
                        cur = (wheel_pos < REPORT_BYTES) ? report_bytes[wheel_pos] : 8'h00;
                        record_write(wheel_pos,
                                     (ev.event_code == KEY_GEAR_DOWN) ? cur - 8'd1 : cur + 8'd1);
                        changed = 1'b1;
                    end
                end
                else if (ev.event_code[15:4] == KEY_BTN_GROUP)
                begin
                    btn = ev.event_code[3:0];
                    if (btn < cur_buttons)
                    begin
                        pos  = 1 + btn / 8;
                        cur  = (pos < REPORT_BYTES) ? report_bytes[pos] : 8'h00;
                        mask = 8'h01 << (btn % 8);
                        record_write(pos, (ev.event_value != 0) ? (cur | mask) : (cur & ~mask));
                        changed = 1'b1;
                    end
                end
            end
            KIND_SYNC:
            begin
                // shared bytes are written once per mapped code, in code order
                for (int c = 0; c < REL_CODES; c++)
                begin
                    slot = slot_for_code(16'(c));
                    if (slot != SLOT_UNMAPPED)
                        record_write(axis_base + slot, 8'h00);
                end
                if (cur_wheel_flags[0] && !cur_wheel_flags[2])
                    record_write(wheel_pos, 8'h00);
            end
            default: ;
        endcase
        foreach (batch[k])
        begin
            batch[k].marks_dirty = changed;
            batch[k].last        = (k == batch.size() - 1);
            expected_writes.push_back(batch[k]);
        end
    endtask

    task automatic compare_field(string name, logic [7:0] expected_val, logic [7:0] actual_val);
        if (expected_val !== actual_val)
        begin
            $error("%s: expected %0h, got %0h", name, expected_val, actual_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (report_bytes[i])
                report_bytes[i] = 8'h00;
            cur_report_id   = 8'd1;
            cur_buttons     = 5'd0;
            cur_axis_bytes  = 4'd0;
            cur_wheel_flags = 5'd0;
            cur_slot_map    = '1;
            expected_writes.delete();
            mismatches = 0;
            backlog   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REPORT_ID:   cur_report_id   = cfg_data[7:0];
                    CFG_NUM_BUTTONS: cur_buttons     = cfg_data[4:0];
                    CFG_AXIS_BYTES:  cur_axis_bytes  = cfg_data[3:0];
                    CFG_WHEEL_FLAGS: cur_wheel_flags = cfg_data[4:0];
                    CFG_SLOT_MAP:    cur_slot_map    = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("unexpected write: byte_index %0d byte_value %0h",
                           out_data.byte_index, out_data.byte_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    compare_field("write_valid", want.write_valid, out_data.write_valid);
                    compare_field("byte_index", want.byte_index, out_data.byte_index);
                    compare_field("byte_value", want.byte_value, out_data.byte_value);
                    compare_field("marks_dirty", want.marks_dirty, out_data.marks_dirty);
                    compare_field("last", want.last, out_data.last);
                end
            end
            if (in_valid && !in_stall)
                predict_writes(in_data);
            backlog <= expected_writes.size();
        end
    end

endmodule

@@ test/tb_input_event_to_mouse_report_unit.sv @@
// Top of the mouse report assembler testbench: clock, reset, config writes and
// event stimulus with random idling on both sides; the verdict comes from
// mouse_report_checker. Depends on mrep_pkg and input_event_to_mouse_report_unit.

module tb_input_event_to_mouse_report_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import mrep_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int EVENTS_PER_SETTING = 16;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    event_t      in_data;
    logic        out_valid;
    logic        out_stall = 1'b0;
    result_t     out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int          mismatches;
    int          backlog;
    int          send_idle_pct = 25;
    int          recv_idle_pct = 66;
    int unsigned cycle_count = 0;

    input_event_to_mouse_report_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mouse_report_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .backlog    (backlog)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_input_event_to_mouse_report_unit NOT OK");
            $finish;
        end
    end

    function automatic event_t ev_of(logic [15:0] k, logic [15:0] c, logic [31:0] v);
        event_t ev;
        ev.kind        = k;
        ev.event_code  = c;
        ev.event_value = v;
        return ev;
    endfunction

    function automatic logic [31:0] draw_motion();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($urandom_range(6)) - 32'd3;
            2:
            begin
                case ($urandom_range(5))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0080;
                    3: return 32'hFFFF_FF80;
                    4: return 32'h0000_007F;
                    default: return 32'hFFFF_FF81;
                endcase
            end
            default: return 32'($urandom_range(400)) - 32'd200;
        endcase
    endfunction

    function automatic event_t draw_event();
        event_t ev;
        int     pick;
        pick           = $urandom_range(99);
        ev.event_value = draw_motion();
        if (pick < 15)
        begin
            ev.kind       = KIND_SYNC;
            ev.event_code = 16'($urandom);
        end
        else if (pick < 50)
        begin
            ev.kind       = KIND_REL;
            ev.event_code = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(15));
        end
        else if (pick < 88)
        begin
            ev.kind = KIND_KEY;
            case ($urandom_range(5))
                0, 1: ev.event_code = KEY_GEAR_DOWN + 16'($urandom_range(1));
                2, 3: ev.event_code = {KEY_BTN_GROUP, 4'($urandom)};
                4:    ev.event_code = 16'($urandom);
                default:
                begin
                    // neighbours of the button and gear codes
                    case ($urandom_range(3))
                        0: ev.event_code = 16'h010F;
                        1: ev.event_code = 16'h0120;
                        2: ev.event_code = 16'h014F;
                        default: ev.event_code = 16'h0152;
                    endcase
                end
            endcase
            if ($urandom_range(2) == 0)
                ev.event_value = '0;
        end
        else
        begin
            ev.kind       = 16'($urandom_range(65535, 3));
            ev.event_code = 16'($urandom);
        end
        return ev;
    endfunction

    function automatic logic [63:0] draw_slot_map();
        logic [63:0] m;
        for (int c = 0; c < REL_CODES; c++)
            m[4 * c +: 4] = ($urandom_range(3) == 0) ? SLOT_UNMAPPED : 4'($urandom_range(14));
        return m;
    endfunction

    // hold valid low until every predicted write has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (backlog != 0);
    endtask

    task automatic send_event(event_t ev, bit settle);
        if (settle)
            drain_results();
        // drop valid while idling so an accepted request is never offered twice
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic apply_settings(logic [7:0] rid, logic [4:0] buttons, logic [3:0] axes,
                                  logic [4:0] wheels, logic [63:0] slot_map);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_REPORT_ID;
        cfg_data  <= 64'(rid);
        @(posedge clk);
        cfg_index <= CFG_NUM_BUTTONS;
        cfg_data  <= 64'(buttons);
        @(posedge clk);
        cfg_index <= CFG_AXIS_BYTES;
        cfg_data  <= 64'(axes);
        @(posedge clk);
        cfg_index <= CFG_WHEEL_FLAGS;
        cfg_data  <= 64'(wheels);
        @(posedge clk);
        cfg_index <= CFG_SLOT_MAP;
        cfg_data  <= slot_map;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_REPORT_ID;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // defaults after reset: nothing mapped, no buttons, no wheel
        send_event(ev_of(KIND_SYNC, 16'h0000, 32'h0), 1'b0);
        send_event(ev_of(KIND_REL, 16'h0000, 32'h5), 1'b0);
        send_event(ev_of(KIND_KEY, KEY_GEAR_UP, 32'h1), 1'b0);
        drain_results();

        // code 7 shares a byte with code 0, code 15 unmapped
        apply_settings(8'h80, 5'd16, 4'd6, 5'h03, 64'hF065_4321_0654_3210);
        send_event(ev_of(KIND_REL, 16'h0000, 32'h7FFF_FFFF), 1'b0);
        send_event(ev_of(KIND_REL, 16'h0001, 32'h8000_0000), 1'b0);
        send_event(ev_of(KIND_REL, 16'h0003, 32'hFFFF_FF80), 1'b0);
        send_event(ev_of(KIND_REL, 16'h0004, 32'h0000_0080), 1'b0);
        send_event(ev_of(KIND_REL, 16'h0007, 32'hFFFF_FF81), 1'b0);
        send_event(ev_of(KIND_REL, 16'h000F, 32'h1), 1'b0);
        send_event(ev_of(KIND_REL, 16'h0010, 32'h1), 1'b0);
        send_event(ev_of(KIND_REL, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
        send_event(ev_of(KIND_KEY, KEY_GEAR_UP, 32'h1), 1'b0);
        send_event(ev_of(KIND_KEY, KEY_GEAR_UP, 32'h8000_0000), 1'b0);
        send_event(ev_of(KIND_KEY, KEY_GEAR_DOWN, 32'h1), 1'b0);
        send_event(ev_of(KIND_KEY, KEY_GEAR_DOWN, 32'h1), 1'b0);
        send_event(ev_of(KIND_KEY, KEY_GEAR_DOWN, 32'h1), 1'b0);
        send_event(ev_of(KIND_KEY, KEY_GEAR_DOWN, 32'h0), 1'b0);
        send_event(ev_of(KIND_KEY, {KEY_BTN_GROUP, 4'h0}, 32'h1), 1'b0);
        send_event(ev_of(KIND_KEY, {KEY_BTN_GROUP, 4'hF}, 32'hFFFF_FFFF), 1'b0);
        send_event(ev_of(KIND_KEY, {KEY_BTN_GROUP, 4'h8}, 32'h8000_0000), 1'b0);
        send_event(ev_of(KIND_KEY, {KEY_BTN_GROUP, 4'h8}, 32'h0), 1'b0);
        send_event(ev_of(KIND_KEY, 16'h0120, 32'h1), 1'b0);
        send_event(ev_of(KIND_KEY, 16'hFFFF, 32'h1), 1'b0);
        send_event(ev_of(KIND_SYNC, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
        send_event(ev_of(16'h0003, 16'h0000, 32'h1), 1'b0);
        send_event(ev_of(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int s = 0; s < 2; s++)
            begin
                drain_results();
                case (ph)
                    0:
                    begin
                        send_idle_pct = 25;
                        recv_idle_pct = 66;
                    end
                    1:
                    begin
                        send_idle_pct = 66;
                        recv_idle_pct = 25;
                    end
                    default:
                    begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                case (ph * 2 + s)
                    0: apply_settings(8'hFF, 5'd16, 4'd14, 5'h1F, draw_slot_map());
                    // every code on one byte, wheel on it too: the longest sync
                    1: apply_settings(8'h00, 5'd0, 4'd0, 5'h01, 64'h0);
                    3: apply_settings(8'($urandom), 5'($urandom_range(16)),
                                      4'($urandom_range(14)), 5'($urandom), '1);
                    default: apply_settings(8'($urandom), 5'($urandom_range(16)),
                                            4'($urandom_range(14)), 5'($urandom),
                                            draw_slot_map());
                endcase
                for (int n = 0; n < EVENTS_PER_SETTING; n++)
                    send_event(draw_event(), n == 11 || $urandom_range(24) == 0);
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("tb_input_event_to_mouse_report_unit OK");
        else
            $display("tb_input_event_to_mouse_report_unit NOT OK");
        $finish;
    end

endmodule
